// ----- rtl/five_tuple_acl_classifier_core_macros.svh -----
// ----------------------------------------------------------------------------
// five-tuple acl classifier assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in rst
// ----------------------------------------------------------------------------
`ifndef FIVE_TUPLE_ACL_CLASSIFIER_CORE_MACROS_SVH
`define FIVE_TUPLE_ACL_CLASSIFIER_CORE_MACROS_SVH

// same-cycle implication
`define FTACL_ASSERT_IMPL(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FTACL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ftacl_pkg.sv -----
// ----------------------------------------------------------------------------
// ftacl_pkg
// types, constants and helpers shared by the acl cell chain and its top level
// ----------------------------------------------------------------------------
package ftacl_pkg;

  localparam int MAX_RULES = 64;
  localparam int IDX_W     = $clog2(MAX_RULES);
  localparam int CNT_W     = $clog2(MAX_RULES + 1);

  localparam logic [1:0] CMD_EVAL = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_DEL  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] src_ip;
    logic [5:0]  src_len;
    logic [31:0] dst_ip;
    logic [5:0]  dst_len;
    logic [7:0]  proto;
    logic [15:0] src_lo;
    logic [15:0] src_hi;
    logic [15:0] dst_lo;
    logic [15:0] dst_hi;
    logic        verdict;
  } rule_t;

  // command under evaluation, broadcast to every cell
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [7:0]  proto;
    logic [15:0] pkt_sport;
    logic [15:0] pkt_dport;
  } op_t;

  // partial result handed from cell to cell
  typedef struct packed {
    logic        hit;
    logic        verdict;
    logic [31:0] id;
  } link_t;

  function automatic logic [31:0] prefix_mask(input logic [5:0] len);
    logic [5:0] n;
    n = (len > 6'd32) ? 6'd32 : len;
    return ~(32'hFFFF_FFFF >> n);
  endfunction

endpackage

// ----- rtl/five_tuple_acl_classifier_core.sv -----
// ----------------------------------------------------------------------------
// five_tuple_acl_classifier_core
// first-match five-tuple acl: a chain of rule cells walked by a token
// ----------------------------------------------------------------------------
// add and unknown commands: result strobe in the cycle after accept
// evaluate and delete: result after go, the token register of every rule cell in
//   order and the result registers; the token steps one rule cell per cycle
// one command in flight; busy stays high until its result strobe (add and unknown leave it low)
// reset empties the table and sets default_deny to 1; results cannot stall
`include "five_tuple_acl_classifier_core_macros.svh"

module five_tuple_acl_classifier_core import ftacl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [31:0] rule_id,
  input  logic [31:0] src_ip,
  input  logic [5:0]  src_prefix_len,
  input  logic [31:0] dst_ip,
  input  logic [5:0]  dst_prefix_len,
  input  logic [7:0]  protocol,
  input  logic [15:0] src_port_lo,
  input  logic [15:0] src_port_hi,
  input  logic [15:0] dst_port_lo,
  input  logic [15:0] dst_port_hi,
  input  logic        rule_verdict_in,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  output logic        done,
  output logic        verdict,
  output logic [1:0]  status,
  output logic        rule_matched,
  output logic [31:0] matched_rule_id
);

  logic             accept;
  logic             full;
  logic [CNT_W-1:0] used_cnt;
  logic             default_deny;
  logic             go;
  op_t              op;
  rule_t            new_rule;
  logic [MAX_RULES-1:0] wr_en;
  logic [MAX_RULES:0]   tok;
  link_t            link [MAX_RULES+1];

  assign accept    = start && !busy;
  assign full      = used_cnt == CNT_W'(MAX_RULES);
  assign cfg_ready = 1'b1;

  assign new_rule = '{id: rule_id, src_ip: src_ip, src_len: src_prefix_len,
                      dst_ip: dst_ip, dst_len: dst_prefix_len, proto: protocol,
                      src_lo: src_port_lo, src_hi: src_port_hi,
                      dst_lo: dst_port_lo, dst_hi: dst_port_hi,
                      verdict: rule_verdict_in};

  assign tok[0]  = go;
  assign link[0] = '0;

  genvar g;
  generate
    for (g = 0; g < MAX_RULES; g++) begin : g_cell
      assign wr_en[g] = accept && (cmd == CMD_ADD) && !full
                        && (used_cnt == CNT_W'(g));
      ftacl_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .idx      (IDX_W'(g)),
        .used_cnt (used_cnt),
        .wr_en    (wr_en[g]),
        .wr_rule  (new_rule),
        .op       (op),
        .tok_in   (tok[g]),
        .link_in  (link[g]),
        .tok_out  (tok[g+1]),
        .link_out (link[g+1])
      );
    end
  endgenerate

  // latch the command for the walk
  always_ff @(posedge clk) begin
    if (accept) begin
      op.cmd       <= cmd;
      op.id        <= rule_id;
      op.src_ip    <= src_ip;
      op.dst_ip    <= dst_ip;
      op.proto     <= protocol;
      op.pkt_sport <= src_port_lo;
      op.pkt_dport <= dst_port_lo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      go           <= 1'b0;
      done         <= 1'b0;
      used_cnt     <= '0;
      default_deny <= 1'b1;
    end else begin
      go   <= accept && ((cmd == CMD_EVAL) || (cmd == CMD_DEL));
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        default_deny <= cfg_data;
      end
      if (accept) begin
        busy <= 1'b1;
        if ((cmd != CMD_EVAL) && (cmd != CMD_DEL)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        if ((cmd == CMD_ADD) && !full) begin
          used_cnt <= used_cnt + 1'b1;
        end
      end
      if (tok[MAX_RULES]) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      verdict         <= 1'b0;
      rule_matched    <= 1'b0;
      matched_rule_id <= '0;
      status          <= ((cmd == CMD_ADD) && full) ? ST_FULL : ST_OK;
    end else if (tok[MAX_RULES]) begin
      if (op.cmd == CMD_EVAL) begin
        verdict         <= link[MAX_RULES].hit ? link[MAX_RULES].verdict : default_deny;
        rule_matched    <= link[MAX_RULES].hit;
        matched_rule_id <= link[MAX_RULES].hit ? link[MAX_RULES].id : 32'd0;
        status          <= ST_OK;
      end else begin
        verdict         <= 1'b0;
        rule_matched    <= 1'b0;
        matched_rule_id <= '0;
        status          <= link[MAX_RULES].hit ? ST_OK : ST_NOT_FOUND;
      end
    end
  end

  `FTACL_ASSERT_IMPL(a_one_token, 1'b1, $onehot0(tok), "more than one transaction in the chain")
  `FTACL_ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while still busy")
  `FTACL_ASSERT_IMPL(a_token_busy, tok != '0, busy, "token walking while idle")
  `FTACL_ASSERT_IMPL(a_used_range, 1'b1, used_cnt <= CNT_W'(MAX_RULES), "rule count overflow")

endmodule

// ----- rtl/ftacl_cell.sv -----
// ----------------------------------------------------------------------------
// ftacl_cell
// one rule slot: stores a rule, tests it when the token passes, hands on
// ----------------------------------------------------------------------------
module ftacl_cell import ftacl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic [IDX_W-1:0] idx,
  input  logic [CNT_W-1:0] used_cnt,
  input  logic             wr_en,
  input  rule_t            wr_rule,
  input  op_t              op,
  input  logic             tok_in,
  input  link_t            link_in,
  output logic             tok_out,
  output link_t            link_out
);

  rule_t rule;
  logic  active;
  logic  in_use;
  logic  pkt_hit;
  logic  id_hit;
  logic  src_any;
  logic  dst_any;
  link_t link_next;
  logic  active_next;

  assign in_use = {1'b0, idx} < used_cnt;

  assign src_any = (rule.src_lo == 16'd0) && (rule.src_hi == 16'd0);
  assign dst_any = (rule.dst_lo == 16'd0) && (rule.dst_hi == 16'd0);

  assign pkt_hit = ((rule.proto == 8'd0) || (rule.proto == op.proto))
    && (((op.src_ip ^ rule.src_ip) & prefix_mask(rule.src_len)) == 32'd0)
    && (((op.dst_ip ^ rule.dst_ip) & prefix_mask(rule.dst_len)) == 32'd0)
    && (src_any || ((op.pkt_sport >= rule.src_lo) && (op.pkt_sport <= rule.src_hi)))
    && (dst_any || ((op.pkt_dport >= rule.dst_lo) && (op.pkt_dport <= rule.dst_hi)));

  assign id_hit = rule.id == op.id;

  always_comb begin
    link_next   = link_in;
    active_next = active;
    if (tok_in && !link_in.hit && in_use && active) begin
      case (op.cmd)
        CMD_EVAL: begin
          if (pkt_hit) begin
            link_next.hit     = 1'b1;
            link_next.verdict = rule.verdict;
            link_next.id      = rule.id;
          end
        end
        CMD_DEL: begin
          if (id_hit) begin
            link_next.hit = 1'b1;
            active_next   = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rule   <= wr_rule;
      active <= 1'b1;
    end else begin
      active <= active_next;
    end
    link_out <= link_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= 1'b0;
    end else begin
      tok_out <= tok_in;
    end
  end

endmodule

// ----- tb/five_tuple_acl_classifier_core_test.sv -----
// ----------------------------------------------------------------------------
// five_tuple_acl_classifier_core_test
// random and directed add, delete and evaluate commands against a rule-table
// predictor; results are compared field by field in order of acceptance
// ----------------------------------------------------------------------------
module five_tuple_acl_classifier_core_test;
  import ftacl_pkg::*;

  typedef struct {
    logic [1:0]  cmd;
    logic [31:0] id;
    logic [31:0] sip;
    logic [5:0]  slen;
    logic [31:0] dip;
    logic [5:0]  dlen;
    logic [7:0]  proto;
    logic [15:0] spl;
    logic [15:0] sph;
    logic [15:0] dpl;
    logic [15:0] dph;
    logic        vin;
  } acl_cmd_t;

  typedef struct {
    logic        verdict;
    logic [1:0]  status;
    logic        matched;
    logic [31:0] mid;
  } acl_res_t;

  class acl_scoreboard;
    acl_cmd_t   table_q[$];
    bit         active_q[$];
    logic       deny_default;
    acl_res_t   pending_q[$];
    int         mismatches;
    int         checked;

    function new();
      deny_default = 1'b1;
      mismatches = 0;
      checked = 0;
    endfunction

    function bit prefix_ok(logic [31:0] a, logic [31:0] p, logic [5:0] len);
      logic [5:0]  n;
      logic [31:0] m;
      n = (len > 6'd32) ? 6'd32 : len;
      m = (n == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - n));
      return ((a ^ p) & m) == 32'd0;
    endfunction

    function bit port_ok(logic [15:0] p, logic [15:0] lo, logic [15:0] hi);
      if (lo == 0 && hi == 0) return 1;
      return p >= lo && p <= hi;
    endfunction

    function void note_command(acl_cmd_t c);
      acl_res_t r;
      r = '{1'b0, ST_OK, 1'b0, 32'd0};
      if (c.cmd == CMD_EVAL) begin
        r.verdict = deny_default;
        foreach (table_q[i]) begin
          if (active_q[i] && (table_q[i].proto == 0 || table_q[i].proto == c.proto) &&
              prefix_ok(c.sip, table_q[i].sip, table_q[i].slen) &&
              prefix_ok(c.dip, table_q[i].dip, table_q[i].dlen) &&
              port_ok(c.spl, table_q[i].spl, table_q[i].sph) &&
              port_ok(c.dpl, table_q[i].dpl, table_q[i].dph)) begin
            r.verdict = table_q[i].vin;
            r.matched = 1'b1;
            r.mid = table_q[i].id;
            break;
          end
        end
      end else if (c.cmd == CMD_ADD) begin
        if (table_q.size() >= MAX_RULES) r.status = ST_FULL;
        else begin
          table_q.push_back(c);
          active_q.push_back(1'b1);
        end
      end else if (c.cmd == CMD_DEL) begin
        r.status = ST_NOT_FOUND;
        foreach (table_q[i]) begin
          if (active_q[i] && table_q[i].id == c.id) begin
            active_q[i] = 1'b0;
            r.status = ST_OK;
            break;
          end
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(acl_res_t a);
      acl_res_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("result with nothing pending: %p", a);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (a.verdict !== e.verdict || a.status !== e.status ||
          a.matched !== e.matched || a.mid !== e.mid) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected v=%0d st=%0d m=%0d id=%h, got v=%0d st=%0d m=%0d id=%h",
                   e.verdict, e.status, e.matched, e.mid,
                   a.verdict, a.status, a.matched, a.mid);
      end
    endfunction
  endclass

  localparam int STALL_LIMIT = 5000;

  logic        clk, rst, start, busy, cfg_valid, cfg_ready, cfg_data, done;
  logic [1:0]  cmd;
  logic [31:0] rule_id, src_ip, dst_ip;
  logic [5:0]  src_prefix_len, dst_prefix_len;
  logic [7:0]  protocol;
  logic [15:0] src_port_lo, src_port_hi, dst_port_lo, dst_port_hi;
  logic        rule_verdict_in, verdict, rule_matched;
  logic [1:0]  status;
  logic [31:0] matched_rule_id;

  acl_scoreboard sb;
  int          idle_cycles;
  int          n_eval, n_add, n_del;
  logic [31:0] used_ids[$];

  five_tuple_acl_classifier_core dut (.*);

  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst && done)
      sb.check_result('{verdict, status, rule_matched, matched_rule_id});
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("watchdog expired");
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int gap_len();
    int n;
    n = ($urandom_range(0, 9) == 0) ? int'($urandom_range(5, 40)) : int'($urandom_range(0, 2));
    if ($urandom_range(0, 3) == 0) n = 0;
    return n;
  endfunction

  // start stays high into a back-to-back transaction; dropped only for a gap
  task automatic issue(acl_cmd_t c);
    int n;
    start <= 1'b1;
    cmd <= c.cmd; rule_id <= c.id; src_ip <= c.sip; src_prefix_len <= c.slen;
    dst_ip <= c.dip; dst_prefix_len <= c.dlen; protocol <= c.proto;
    src_port_lo <= c.spl; src_port_hi <= c.sph; dst_port_lo <= c.dpl;
    dst_port_hi <= c.dph; rule_verdict_in <= c.vin;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(c);
    if (c.cmd == CMD_EVAL) n_eval++;
    else if (c.cmd == CMD_ADD) n_add++;
    else if (c.cmd == CMD_DEL) n_del++;
    n = gap_len();
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (MAX_RULES + 8) @(posedge clk);
  endtask

  task automatic write_default(logic v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.deny_default = v;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic acl_cmd_t rand_cmd(logic [1:0] k);
    acl_cmd_t c;
    c.cmd = k;
    c.id = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
    c.sip = $urandom(); c.dip = $urandom();
    c.slen = 6'($urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 12));
    c.dlen = 6'($urandom_range(0, 5) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 12));
    c.proto = 8'($urandom_range(0, 2) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 3));
    c.spl = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom());
    c.sph = c.spl == 0 ? 16'd0 : ($urandom_range(0, 7) == 0 ? 16'($urandom()) : 16'hFFFF);
    c.dpl = $urandom_range(0, 3) == 0 ? 16'd0 : 16'($urandom_range(0, 32768));
    c.dph = c.dpl == 0 ? 16'd0 : 16'($urandom());
    c.vin = 1'($urandom_range(0, 1));
    // steer packets toward stored rules so first-match ordering is exercised
    if (k == CMD_EVAL && sb.table_q.size() != 0 && $urandom_range(0, 3) != 0) begin
      acl_cmd_t r;
      r = sb.table_q[$urandom_range(0, sb.table_q.size() - 1)];
      c.sip = (r.sip & 32'hFFF0_0000) | (c.sip & 32'h000F_FFFF);
      c.dip = (r.dip & 32'hFFF0_0000) | (c.dip & 32'h000F_FFFF);
      if (r.proto != 0) c.proto = r.proto;
      if (!(r.spl == 0 && r.sph == 0) && r.spl <= r.sph)
        c.spl = 16'($urandom_range(r.spl, r.sph));
      if (!(r.dpl == 0 && r.dph == 0) && r.dpl <= r.dph)
        c.dpl = 16'($urandom_range(r.dpl, r.dph));
    end
    if (k == CMD_DEL && sb.table_q.size() != 0 && $urandom_range(0, 2) != 0)
      c.id = sb.table_q[$urandom_range(0, sb.table_q.size() - 1)].id;
    return c;
  endfunction

  initial begin
    acl_cmd_t c;
    sb = new();
    n_eval = 0; n_add = 0; n_del = 0;
    rst <= 1'b1; start <= 1'b0; cfg_valid <= 1'b0; cfg_data <= 1'b0;
    cmd <= CMD_EVAL; rule_id <= '0; src_ip <= '0; dst_ip <= '0;
    src_prefix_len <= '0; dst_prefix_len <= '0; protocol <= '0;
    src_port_lo <= '0; src_port_hi <= '0; dst_port_lo <= '0; dst_port_hi <= '0;
    rule_verdict_in <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, unknown command, delete misses
    c = '{CMD_EVAL, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    issue(c);
    c = '{2'd3, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1};
    issue(c);
    c = '{CMD_DEL, 32'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    issue(c);
    // exact-match rule with oversize prefix lengths
    c = '{CMD_ADD, 32'd7, 32'hC0A8_0001, 6'd63, 32'h0A00_0001, 6'd33, 8'd6,
          16'd80, 16'd80, 16'd1, 16'hFFFF, 1'b0};
    issue(c);
    // inverted range: never matches
    c = '{CMD_ADD, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 16'd9, 16'd3, 0, 0, 1'b0};
    issue(c);
    // duplicate id, wildcard everything, deny
    c = '{CMD_ADD, 32'd7, '1, 6'd0, '1, 6'd0, 8'd0, 0, 0, 0, 0, 1'b1};
    issue(c);
    c = '{CMD_EVAL, 0, 32'hC0A8_0001, 0, 32'h0A00_0001, 0, 8'd6, 16'd80, 0, 16'hFFFF, 0, 0};
    issue(c);
    c = '{CMD_EVAL, 0, 32'hC0A8_0002, 0, 32'h0A00_0001, 0, 8'd17, 16'd5, 0, 16'd0, 0, 0};
    issue(c);
    c = '{CMD_DEL, 32'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    issue(c);
    c = '{CMD_EVAL, 0, 32'hC0A8_0001, 0, 32'h0A00_0001, 0, 8'd6, 16'd80, 0, 16'd1, 0, 0};
    issue(c);
    c = '{CMD_DEL, 32'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    issue(c);
    issue(c);
    c = '{CMD_EVAL, 0, '1, 0, '1, 0, 8'hFF, 16'hFFFF, 0, 16'hFFFF, 0, 0};
    issue(c);
    write_default(1'b0);
    issue(c);
    write_default(1'b1);

    // random phases; table fills after 64 adds, later adds report full
    for (int ph = 0; ph < 6; ph++) begin
      for (int k = 0; k < 150; k++) begin
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) c = rand_cmd(CMD_EVAL);
        else if (r < 75) c = rand_cmd(CMD_ADD);
        else if (r < 95) c = rand_cmd(CMD_DEL);
        else c = rand_cmd(2'd3);
        if ($urandom_range(0, 40) == 0) c.id = '1;
        issue(c);
      end
      write_default(1'($urandom_range(0, 1)));
    end

    drain();
    $display("covered %0d evaluates, %0d adds, %0d deletes; %0d results checked",
             n_eval, n_add, n_del, sb.checked);
    $display("table held %0d rules at the end", sb.table_q.size());
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("simulation failed");
    end
    $finish;
  end
endmodule
